### hdl/pit_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the point-in-triangle test core
// no dependencies; imported by the front, queue, back and top modules

package pit_pkg;

    // dot products carried from front to back, in slot order
    localparam int NUM_DOTS = 5;
    localparam int DOT_D00  = 0;   // e0 . e0
    localparam int DOT_D01  = 1;   // e0 . e1
    localparam int DOT_D11  = 2;   // e1 . e1
    localparam int DOT_D02  = 3;   // e0 . w
    localparam int DOT_D12  = 4;   // e1 . w

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

### hdl/pit_front.sv
`timescale 1ns / 1ps
// front part: accepts a triangle/point transfer and forms the five dot products
// depends on pit_pkg; feeds pit_fifo

module pit_front
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [12*COORD_WIDTH-1:0]             in_data,
    input  fifo_stat_t                            q_stat,
    output logic                                  out_valid,
    output logic [NUM_DOTS*(2*COORD_WIDTH+4)-1:0] out_data
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2*W + 2;   // one coordinate product
    localparam int DW = 2*W + 4;   // three-term dot product

    logic v1_reg, v2_reg, v3_reg;
    logic en;

    logic signed [W:0]    e0_next [3];
    logic signed [W:0]    e1_next [3];
    logic signed [W:0]    w_next  [3];
    logic signed [W:0]    e0_reg  [3];
    logic signed [W:0]    e1_reg  [3];
    logic signed [W:0]    w_reg   [3];

    logic signed [PW-1:0] p00_reg [3];
    logic signed [PW-1:0] p01_reg [3];
    logic signed [PW-1:0] p11_reg [3];
    logic signed [PW-1:0] p02_reg [3];
    logic signed [PW-1:0] p12_reg [3];

    logic signed [DW-1:0] dot_next [NUM_DOTS];
    logic signed [DW-1:0] dot_reg  [NUM_DOTS];

    // pipeline moves unless the last stage is blocked by a full queue
    assign en        = !v3_reg || !q_stat.full;
    assign in_ready  = en;
    assign out_valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // edge vectors e0 = C - A, e1 = B - A and offset w = P - A
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e0_next[i] = $signed({in_data[(6+i)*W+W-1], in_data[(6+i)*W +: W]})
                       - $signed({in_data[i*W+W-1], in_data[i*W +: W]});
            e1_next[i] = $signed({in_data[(3+i)*W+W-1], in_data[(3+i)*W +: W]})
                       - $signed({in_data[i*W+W-1], in_data[i*W +: W]});
            w_next[i]  = $signed({in_data[(9+i)*W+W-1], in_data[(9+i)*W +: W]})
                       - $signed({in_data[i*W+W-1], in_data[i*W +: W]});
        end
    end

    // dot product sums over the three axes
    always_comb
    begin
        dot_next[DOT_D00] = DW'(p00_reg[0]) + DW'(p00_reg[1]) + DW'(p00_reg[2]);
        dot_next[DOT_D01] = DW'(p01_reg[0]) + DW'(p01_reg[1]) + DW'(p01_reg[2]);
        dot_next[DOT_D11] = DW'(p11_reg[0]) + DW'(p11_reg[1]) + DW'(p11_reg[2]);
        dot_next[DOT_D02] = DW'(p02_reg[0]) + DW'(p02_reg[1]) + DW'(p02_reg[2]);
        dot_next[DOT_D12] = DW'(p12_reg[0]) + DW'(p12_reg[1]) + DW'(p12_reg[2]);
    end

    // payload stages: differences, per-axis products, dot products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e0_reg[i]  <= e0_next[i];
                e1_reg[i]  <= e1_next[i];
                w_reg[i]   <= w_next[i];
                p00_reg[i] <= e0_reg[i] * e0_reg[i];
                p01_reg[i] <= e0_reg[i] * e1_reg[i];
                p11_reg[i] <= e1_reg[i] * e1_reg[i];
                p02_reg[i] <= e0_reg[i] * w_reg[i];
                p12_reg[i] <= e1_reg[i] * w_reg[i];
            end
            for (int k = 0; k < NUM_DOTS; k++)
            begin
                dot_reg[k] <= dot_next[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_DOTS; k++)
        begin
            out_data[k*DW +: DW] = dot_reg[k];
        end
    end

endmodule

### hdl/pit_fifo.sv
`timescale 1ns / 1ps
// short register queue between the front and back parts
// depends on pit_pkg for the status struct

module pit_fifo
    import pit_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data,
    output fifo_stat_t       stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign push       = wr_valid && !stat.full;
    assign pop        = rd_ready && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/pit_back.sv
`timescale 1ns / 1ps
// back part: Cramer terms from the dot products and the inside decision
// depends on pit_pkg; fed by pit_fifo, drives the result register

module pit_back
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fifo_stat_t                            q_stat,
    output logic                                  in_ready,
    input  logic [NUM_DOTS*(2*COORD_WIDTH+4)-1:0] in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  inside_res,
    output logic                                  degenerate
);

    localparam int DW  = 2*COORD_WIDTH + 4;   // dot product width (even)
    localparam int H   = DW / 2;              // low half, unsigned
    localparam int HW  = DW - H;              // high half, signed
    localparam int PPW = DW + 2;              // partial product register
    localparam int CW  = 2*DW + 2;            // Cramer term width
    localparam int NP  = 6;

    // operand slots of the six Cramer products
    localparam int OPA [NP] = '{DOT_D00, DOT_D01, DOT_D11, DOT_D01, DOT_D00, DOT_D01};
    localparam int OPB [NP] = '{DOT_D11, DOT_D01, DOT_D02, DOT_D12, DOT_D12, DOT_D02};

    logic bv1_reg, bv2_reg, bv3_reg, bv4_reg, vo_reg;
    logic en;

    logic signed [HW-1:0]  ah [NP];
    logic signed [HW-1:0]  bh [NP];
    logic signed [H:0]     al [NP];
    logic signed [H:0]     bl [NP];

    logic signed [PPW-1:0] hh_reg [NP];
    logic signed [PPW-1:0] hl_reg [NP];
    logic signed [PPW-1:0] lh_reg [NP];
    logic signed [PPW-1:0] ll_reg [NP];

    logic signed [CW-1:0]  prod_next [NP];
    logic signed [CW-1:0]  prod_reg  [NP];

    logic signed [CW-1:0]  den_reg, un_reg, vn_reg;
    logic signed [CW-1:0]  den4_reg, sum_reg;
    logic signed [CW-1:0]  slack;
    logic                  ok_reg, degen_reg;
    logic                  inside_reg, degen_out_reg;

    // whole back pipeline stalls only when the result waits
    assign en         = !vo_reg || out_ready;
    assign in_ready   = en;
    assign out_valid  = vo_reg;
    assign inside_res = inside_reg;
    assign degenerate = degen_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv1_reg <= 1'b0;
            bv2_reg <= 1'b0;
            bv3_reg <= 1'b0;
            bv4_reg <= 1'b0;
            vo_reg  <= 1'b0;
        end
        else if (en)
        begin
            bv1_reg <= !q_stat.empty;
            bv2_reg <= bv1_reg;
            bv3_reg <= bv2_reg;
            bv4_reg <= bv3_reg;
            vo_reg  <= bv4_reg;
        end
    end

    // split operands into signed high and zero-extended low halves
    always_comb
    begin
        for (int j = 0; j < NP; j++)
        begin
            ah[j] = $signed(in_data[OPA[j]*DW + H +: HW]);
            bh[j] = $signed(in_data[OPB[j]*DW + H +: HW]);
            al[j] = $signed({1'b0, in_data[OPA[j]*DW +: H]});
            bl[j] = $signed({1'b0, in_data[OPB[j]*DW +: H]});
        end
    end

    // recombine partial products into full Cramer products
    always_comb
    begin
        for (int j = 0; j < NP; j++)
        begin
            prod_next[j] = (CW'(hh_reg[j]) <<< (2*H))
                         + ((CW'(hl_reg[j]) + CW'(lh_reg[j])) <<< H)
                         + CW'(ll_reg[j]);
        end
    end

    assign slack = den4_reg - sum_reg;

    // payload stages: partials, products, terms, sum, decision
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NP; j++)
            begin
                hh_reg[j]   <= PPW'(ah[j] * bh[j]);
                hl_reg[j]   <= PPW'(ah[j] * bl[j]);
                lh_reg[j]   <= PPW'(al[j] * bh[j]);
                ll_reg[j]   <= PPW'(al[j] * bl[j]);
                prod_reg[j] <= prod_next[j];
            end
            den_reg       <= prod_reg[0] - prod_reg[1];
            un_reg        <= prod_reg[2] - prod_reg[3];
            vn_reg        <= prod_reg[4] - prod_reg[5];
            den4_reg      <= den_reg;
            sum_reg       <= un_reg + vn_reg;
            ok_reg        <= !un_reg[CW-1] && !vn_reg[CW-1];
            degen_reg     <= (den_reg == '0);
            inside_reg    <= !degen_reg && ok_reg && !slack[CW-1];
            degen_out_reg <= degen_reg;
        end
    end

endmodule

### hdl/point_in_triangle_test_core.sv
`timescale 1ns / 1ps
// top level of the point-in-triangle test core
// depends on pit_pkg, pit_front, pit_fifo and pit_back
//
// usage
//   s_* channel: one transfer carries the corners A, B, C and the query
//   point P as twelve signed COORD_WIDTH-bit coordinates.
//   m_* channel: one transfer per query; m_tdata bit 0 is inside_res
//   (bounds inclusive), m_tuser is degenerate (zero-area triangle, which
//   always reports outside). Points off the plane are judged by their
//   projection onto it.
//   path: the result passes through the three front stages, one queue slot,
//   four Cramer stages and the result reg.
//   throughput: one query per cycle while m_tready stays high, set by the
//   fully pipelined multiplier stages; each Cramer product is split into
//   four half-width partials; no multiplier input tops COORD_WIDTH+3 bits.
//   stall: when a result waits with m_tready low the back pipeline holds;
//   the front keeps accepting until the QUEUE_DEPTH-entry queue is full and
//   its own last stage holds a query, then s_tready drops.
//   reset: rst_n clears all valid flags and the queue; no result is pending
//   afterwards and no clearing pass is needed.

module point_in_triangle_test_core
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z, zero pad
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // inside_res, zero pad
    output logic [7:0]                             m_tdata,
    // degenerate
    output logic [0:0]                             m_tuser
);

    localparam int DW   = 2*COORD_WIDTH + 4;
    localparam int QW   = NUM_DOTS * DW;

    fifo_stat_t    q_stat;
    logic          f_valid;
    logic [QW-1:0] f_data;
    logic          b_ready;
    logic [QW-1:0] q_data;
    logic          inside_res;
    logic          degenerate;

    // front: accept and form dot products
    pit_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata[12*COORD_WIDTH-1:0]),
        .q_stat   (q_stat),
        .out_valid(f_valid),
        .out_data (f_data)
    );

    // decoupling queue
    pit_fifo #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_valid(f_valid),
        .wr_data (f_data),
        .rd_ready(b_ready),
        .rd_data (q_data),
        .stat    (q_stat)
    );

    // back: Cramer terms and decision
    pit_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .in_ready  (b_ready),
        .in_data   (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .inside_res(inside_res),
        .degenerate(degenerate)
    );

    assign m_tdata = {7'b0, inside_res};
    assign m_tuser = degenerate;

`ifndef NO_ASSERTIONS
    // a degenerate triangle never reports inside
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tdata[0])
        else $error("degenerate result reported inside");

    // queue status codes are exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // a blocked front stage must hold off new input transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && f_valid) |-> !s_tready)
        else $error("input accepted while front is blocked");
`endif

endmodule
